@@ sv/kla_pkg.sv @@
// Shared types, constants and helpers for the k-th ancestor block.
// No dependencies; used by kla_ctrl and kth_ancestor_binary_lifting.
`default_nettype none

package kla_pkg;

   // Table geometry.
   localparam int MAX_NODES = 1024;
   localparam int LEVELS    = 10;

   // Field widths fixed by the interface.
   localparam int NODE_W = 10;
   localparam int CMD_W  = 2;
   localparam int STEP_W = 20;

   // Derived widths.
   localparam int ROW_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int LVLC_W = $clog2(LEVELS + 1);
   localparam int ADDR_W = ROW_W + LVL_W;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [NODE_W-1:0] node_id;
      logic [NODE_W-1:0] parent_node;
      logic [STEP_W-1:0] steps_up;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic              found;
   } rsp_type;

   // A real node: nonzero and inside the table.
   function automatic logic node_ok(input logic [NODE_W-1:0] n);
      return (n != '0) && (32'(n) < MAX_NODES);
   endfunction

   // Out-of-range node numbers collapse to "no node".
   function automatic logic [NODE_W-1:0] clamp_node(input logic [NODE_W-1:0] n);
      return (32'(n) < MAX_NODES) ? n : '0;
   endfunction

   // Table row of a node number already known to be in range.
   function automatic logic [ROW_W-1:0] to_row(input logic [NODE_W-1:0] n);
      return ROW_W'(n);
   endfunction

endpackage

`default_nettype wire

@@ sv/kla_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instantiated by kla_ctrl for the ancestor table.
`default_nettype none

module kla_ram #(
   parameter int ADDR_W = 14,
   parameter int DATA_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/kla_ctrl.sv @@
// Sequencer for table clear, parent load, level build and ancestor walk.
// Depends on kla_pkg and kla_ram; the single RAM read port is the shared unit.
`default_nettype none

module kla_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   output logic                  cmd_ready,
   input  wire kla_pkg::req_type cmd_data,
   output logic                  res_valid,
   input  wire logic             res_ready,
   output kla_pkg::rsp_type      res_data
);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_B_RD1  = 8'b0000_0100,
      ST_B_RD2  = 8'b0000_1000,
      ST_B_WR   = 8'b0001_0000,
      ST_Q_STEP = 8'b0010_0000,
      ST_Q_WAIT = 8'b0100_0000,
      ST_Q_DONE = 8'b1000_0000
   } state_type;

   localparam logic [kla_pkg::ROW_W-1:0]  LAST_ROW = kla_pkg::ROW_W'(kla_pkg::MAX_NODES - 1);
   localparam logic [kla_pkg::LVLC_W-1:0] TOP_LVL  = kla_pkg::LVLC_W'(kla_pkg::LEVELS - 1);
   localparam logic [kla_pkg::LVLC_W-1:0] END_LVL  = kla_pkg::LVLC_W'(kla_pkg::LEVELS);

   state_type                    state_ff, state_in;
   logic [kla_pkg::ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [kla_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [kla_pkg::LVLC_W-1:0]   lvl_ff, lvl_in;
   logic [kla_pkg::NODE_W-1:0]   cur_ff, cur_in;
   logic [kla_pkg::LEVELS-1:0]   k_ff, k_in;

   logic                         ram_we;
   logic [kla_pkg::ADDR_W-1:0]   ram_waddr;
   logic [kla_pkg::NODE_W-1:0]   ram_wdata;
   logic [kla_pkg::ADDR_W-1:0]   ram_raddr;
   logic [kla_pkg::NODE_W-1:0]   ram_rdata;

   logic [kla_pkg::LVL_W-1:0]    lvl_cur;
   logic [kla_pkg::LVL_W-1:0]    lvl_prev;
   logic                         accept;

   kla_ram #(
      .ADDR_W (kla_pkg::ADDR_W),
      .DATA_W (kla_pkg::NODE_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign cmd_ready = (state_ff == ST_IDLE);
   assign accept    = cmd_valid && cmd_ready;
   assign lvl_cur   = lvl_ff[kla_pkg::LVL_W-1:0];
   assign lvl_prev  = kla_pkg::LVL_W'(lvl_ff - 1'b1);

   assign res_valid         = (state_ff == ST_Q_DONE);
   assign res_data.ancestor = cur_ff;
   assign res_data.found    = (cur_ff != '0);

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      row_in      = row_ff;
      lvl_in      = lvl_ff;
      cur_in      = cur_ff;
      k_in        = k_ff;
      ram_we      = 1'b0;
      ram_waddr   = '0;
      ram_wdata   = '0;
      ram_raddr   = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               case (cmd_data.cmd)
                  kla_pkg::CMD_LOAD: begin
                     if (kla_pkg::node_ok(cmd_data.node_id)) begin
                        ram_we    = 1'b1;
                        ram_waddr = {kla_pkg::to_row(cmd_data.node_id),
                                     kla_pkg::LVL_W'(0)};
                        ram_wdata = kla_pkg::clamp_node(cmd_data.parent_node);
                     end
                  end
                  kla_pkg::CMD_BUILD: begin
                     if (kla_pkg::LEVELS > 1) begin
                        row_in   = '0;
                        lvl_in   = kla_pkg::LVLC_W'(1);
                        state_in = ST_B_RD1;
                     end
                  end
                  kla_pkg::CMD_QUERY: begin
                     k_in   = cmd_data.steps_up[kla_pkg::LEVELS-1:0];
                     lvl_in = '0;
                     if (kla_pkg::node_ok(cmd_data.node_id) &&
                         ((cmd_data.steps_up >> kla_pkg::LEVELS) == '0)) begin
                        cur_in   = cmd_data.node_id;
                        state_in = ST_Q_STEP;
                     end else begin
                        cur_in   = '0;
                        state_in = ST_Q_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_B_RD1: begin
            ram_raddr = {row_ff, lvl_prev};
            state_in  = ST_B_RD2;
         end

         ST_B_RD2: begin
            ram_raddr = {kla_pkg::to_row(kla_pkg::clamp_node(ram_rdata)), lvl_prev};
            state_in  = ST_B_WR;
         end

         ST_B_WR: begin
            ram_we    = 1'b1;
            ram_waddr = {row_ff, lvl_cur};
            ram_wdata = ram_rdata;
            if (row_ff == LAST_ROW) begin
               row_in = '0;
               if (lvl_ff == TOP_LVL) begin
                  state_in = ST_IDLE;
               end else begin
                  lvl_in   = lvl_ff + 1'b1;
                  state_in = ST_B_RD1;
               end
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = ST_B_RD1;
            end
         end

         ST_Q_STEP: begin
            if ((lvl_ff == END_LVL) || (cur_ff == '0)) begin
               state_in = ST_Q_DONE;
            end else if (k_ff[lvl_cur]) begin
               ram_raddr = {kla_pkg::to_row(cur_ff), lvl_cur};
               state_in  = ST_Q_WAIT;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end

         ST_Q_WAIT: begin
            cur_in   = kla_pkg::clamp_node(ram_rdata);
            lvl_in   = lvl_ff + 1'b1;
            state_in = ST_Q_STEP;
         end

         ST_Q_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
      row_ff <= row_in;
      lvl_ff <= lvl_in;
      cur_ff <= cur_in;
      k_ff   <= k_in;
   end

endmodule

`default_nettype wire

@@ sv/kth_ancestor_binary_lifting.sv @@
// K-th ancestor by binary lifting over a MAX_NODES x LEVELS table in one RAM.
// After reset a clearing pass zeroes all 2**ADDR_W entries with req_ready low.
// Load: one parent entry write. Build: three RAM accesses per entry.
// Query: at most one dependent RAM read per set bit of steps_up.
// One item at a time; the RAM read port sets the pace. Result sits in an output register.
// Depends on kla_pkg and kla_ctrl (which holds kla_ram).
`default_nettype none

module kth_ancestor_binary_lifting (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire kla_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output kla_pkg::rsp_type      rsp_data
);

   logic             res_valid;
   logic             res_ready;
   kla_pkg::rsp_type res_data;

   logic             rsp_valid_ff, rsp_valid_in;
   kla_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Sequencer: clear pass, loads, level build and ancestor walk.
   kla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_valid),
      .cmd_ready (req_ready),
      .cmd_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   // Take a new result beat whenever the output register is empty or draining.
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         // load the finished query beat
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         // drop the beat once it is taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
